FILE: hdl/sbba_pkg.sv
// Package for the slab bitmap block allocator.
// Holds the request and response payload types and status codes; no dependencies.
`default_nettype none
package sbba_pkg;

  typedef struct packed {
    logic       mode;
    logic [2:0] slab_index;
    logic [7:0] block_index;
  } req_t;

  typedef struct packed {
    logic       ok;
    logic [1:0] status;
    logic [2:0] out_slab;
    logic [7:0] out_block;
  } rsp_t;

  localparam logic       MODE_ALLOC = 1'b0;
  localparam logic       MODE_FREE  = 1'b1;

  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_EXHAUSTED = 2'd1;
  localparam logic [1:0] ST_IGNORED   = 2'd2;
  localparam logic [1:0] ST_CORRUPT   = 2'd3;

  localparam logic [63:0] ALL_ONES = 64'hffff_ffff_ffff_ffff;

endpackage
`default_nettype wire

FILE: hdl/sbba_lsb.sv
// Lowest-clear-bit finder over one 64-bit map word, one register stage.
// Takes scoped names from sbba_pkg for nothing; standalone.
`default_nettype none
module sbba_lsb (
  input  wire logic        clk,
  input  wire logic [63:0] word,
  output logic      [5:0]  pos
);

  logic [63:0] inv;
  logic [5:0]  pos_comb;

  // Priority search over 64 clear bits, written as a two-level split.
  always_comb begin
    logic [7:0] grp_nz;
    logic [2:0] g;
    logic [7:0] sub;
    inv = ~word;
    g   = 3'd0;
    sub = 8'd0;
    for (int i = 0; i < 8; i++) begin
      grp_nz[i] = |inv[i*8 +: 8];
    end
    for (int i = 7; i >= 0; i--) begin
      if (grp_nz[i]) begin
        g = 3'(i);
      end
    end
    sub = inv[{g, 3'b000} +: 8];
    pos_comb = {g, 3'd0};
    for (int j = 7; j >= 0; j--) begin
      if (sub[j]) begin
        pos_comb = {g, 3'(j)};
      end
    end
  end

  always_ff @(posedge clk) begin
    pos <= pos_comb;
  end

endmodule
`default_nettype wire

FILE: hdl/slab_bitmap_block_allocator.sv
// Top level of the slab bitmap block allocator: sequencer, map memory and lists.
// Depends on sbba_pkg and sbba_lsb.
//
//  channel | valid     | ready     | payload
//  request | req_valid | req_ready | req  (sbba_pkg::req_t)
//  result  | rsp_valid | rsp_ready | rsp  (sbba_pkg::rsp_t)
//
// One request is in work at a time. An allocate reads and scans the map words
// in turn, up to four, until one is not all ones, then sets its lowest clear
// bit; when it first claims a fresh slab it writes all four map words first.
// A served free makes four word reads, a fullness check and the clearing write.
// A free of a full slab that is not at the head of the full list adds a walk
// along that list, one link a cycle. Refused requests go straight to the
// result. The next request can transfer in the cycle after the result does,
// and a stalled result holds the block. Reset clears the list heads and
// in-use bits at once; no clearing pass.
`default_nettype none
module slab_bitmap_block_allocator #(
  parameter int NUM_SLABS = 8
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_ready,
  input  wire sbba_pkg::req_t req,
  output logic                rsp_valid,
  input  wire logic           rsp_ready,
  output sbba_pkg::rsp_t      rsp
);

  localparam int SW  = $clog2(NUM_SLABS);
  localparam int LW  = SW + 1;
  localparam int AW  = SW + 2;
  localparam logic [LW-1:0] LNULL = LW'(NUM_SLABS);

  typedef enum logic [3:0] {
    S_IDLE, S_CLAIM, S_RD, S_SCAN, S_SET, S_FRD, S_FCHK, S_WALK, S_FCLR, S_RSP
  } state_t;

  state_t state;

  // Map memory, one 64-bit word per entry, read data registered.
  logic [63:0] mem [NUM_SLABS*4];
  logic [63:0] rdata;
  logic        we;
  logic [AW-1:0] waddr, raddr;
  logic [63:0] wdata;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  logic [NUM_SLABS-1:0] in_use;
  logic [LW-1:0] links [NUM_SLABS];
  logic [LW-1:0] partial_head, full_head;
  // One flag per map word that is set when the word is all ones.
  logic [3:0]    wfull [NUM_SLABS];

  logic [SW-1:0] cur_slab;
  logic [1:0]    widx;
  logic [7:0]    blk;
  logic [3:0]    full_cnt;
  logic [LW-1:0] walk;
  logic [LW:0]   steps;
  logic [63:0]   word_hold;
  logic [5:0]    bitpos;
  logic          lsb_valid;

  sbba_lsb u_lsb (.clk(clk), .word(rdata), .pos(bitpos));

  // Lowest unused slab.
  logic [SW-1:0] free_slab;
  logic          any_free;
  always_comb begin
    free_slab = '0;
    any_free  = 1'b0;
    for (int i = NUM_SLABS - 1; i >= 0; i--) begin
      if (!in_use[i]) begin
        free_slab = SW'(i);
        any_free  = 1'b1;
      end
    end
  end

  function automatic logic [LW-1:0] lnk(input logic [LW-1:0] v);
    return (v < LNULL) ? v : LNULL;
  endfunction

  // The slab is full once the set word is all ones and every other word already was.
  logic [63:0] set_word;
  logic        becomes_full;
  always_comb begin
    set_word     = word_hold | (64'd1 << bitpos);
    becomes_full = (set_word == sbba_pkg::ALL_ONES) &&
                   (&(wfull[cur_slab] | (4'b0001 << widx)));
  end

  assign req_ready = (state == S_IDLE);

  // Memory port control. From the fullness check on, a free holds the target word on the read port.
  always_comb begin
    we    = 1'b0;
    waddr = {cur_slab, widx};
    wdata = set_word;
    raddr = {cur_slab, widx};
    unique case (state)
      S_CLAIM: begin
        we    = 1'b1;
        wdata = (widx == 2'd0) ? 64'd1 : 64'd0;
      end
      S_SET:  we = 1'b1;
      S_FCLR: begin
        we    = 1'b1;
        waddr = {cur_slab, blk[7:6]};
        raddr = {cur_slab, blk[7:6]};
        wdata = rdata & ~(64'd1 << blk[5:0]);
      end
      S_FCHK, S_WALK: raddr = {cur_slab, blk[7:6]};
      default: ;
    endcase
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      in_use       <= '0;
      partial_head <= LNULL;
      full_head    <= LNULL;
      rsp_valid    <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            blk      <= req.block_index;
            widx     <= 2'd0;
            full_cnt <= 4'd0;
            if (req.mode == sbba_pkg::MODE_ALLOC) begin
              if (partial_head < LNULL) begin
                cur_slab <= partial_head[SW-1:0];
                state    <= S_RD;
              end else if (any_free) begin
                cur_slab <= free_slab;
                state    <= S_CLAIM;
              end else begin
                rsp   <= '{1'b0, sbba_pkg::ST_EXHAUSTED, 3'd0, 8'd0};
                state <= S_RSP;
              end
            end else if (req.block_index == 8'd0 ||
                         int'(req.slab_index) >= NUM_SLABS ||
                         !in_use[SW'(req.slab_index)]) begin
              rsp   <= '{1'b0, sbba_pkg::ST_IGNORED, 3'd0, 8'd0};
              state <= S_RSP;
            end else begin
              cur_slab <= SW'(req.slab_index);
              state    <= S_FRD;
            end
          end
        end
        // Claim: write the fresh map word by word.
        S_CLAIM: begin
          widx <= widx + 2'd1;
          if (widx == 2'd3) begin
            in_use[cur_slab] <= 1'b1;
            links[cur_slab]  <= LNULL;
            wfull[cur_slab]  <= 4'b0000;
            partial_head     <= LW'(cur_slab);
            state            <= S_RD;
          end
        end
        S_RD: begin
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (rdata != sbba_pkg::ALL_ONES) begin
            word_hold <= rdata;
            state     <= S_SET;
          end else if (widx == 2'd3) begin
            rsp   <= '{1'b0, sbba_pkg::ST_CORRUPT, 3'd0, 8'd0};
            state <= S_RSP;
          end else begin
            widx  <= widx + 2'd1;
            state <= S_RD;
          end
        end
        S_SET: begin
          wfull[cur_slab][widx] <= (set_word == sbba_pkg::ALL_ONES);
          if (becomes_full) begin
            partial_head    <= lnk(links[cur_slab]);
            links[cur_slab] <= full_head;
            full_head       <= LW'(cur_slab);
          end
          rsp   <= '{1'b1, sbba_pkg::ST_DONE, 3'(cur_slab), {widx, bitpos}};
          state <= S_RSP;
        end
        // Free: read all four words to learn fullness, then the target word.
        S_FRD: begin
          widx <= widx + 2'd1;
          if (widx != 2'd0 || full_cnt != 4'd0) begin
            full_cnt <= full_cnt + 4'((rdata == sbba_pkg::ALL_ONES) ? 1 : 0);
          end
          if (widx == 2'd3) begin
            state <= S_FCHK;
          end
        end
        S_FCHK: begin
          // rdata holds word 3 here; the target word arrives next cycle.
          if ((full_cnt + 4'((rdata == sbba_pkg::ALL_ONES) ? 1 : 0)) == 4'd4) begin
            if (full_head == LW'(cur_slab)) begin
              full_head       <= lnk(links[cur_slab]);
              links[cur_slab] <= partial_head;
              partial_head    <= LW'(cur_slab);
              state           <= S_FCLR;
            end else begin
              walk  <= full_head;
              steps <= '0;
              state <= S_WALK;
            end
          end else begin
            state <= S_FCLR;
          end
          full_cnt <= 4'd0;
        end
        S_WALK: begin
          if (steps >= (LW+1)'(NUM_SLABS) || walk >= LNULL) begin
            state <= S_FCLR;
          end else if (lnk(links[walk[SW-1:0]]) == LW'(cur_slab)) begin
            links[walk[SW-1:0]] <= lnk(links[cur_slab]);
            links[cur_slab]     <= partial_head;
            partial_head        <= LW'(cur_slab);
            state               <= S_FCLR;
          end else begin
            walk  <= lnk(links[walk[SW-1:0]]);
            steps <= steps + 1'b1;
          end
        end
        // The cleared word can no longer be all ones.
        S_FCLR: begin
          wfull[cur_slab][blk[7:6]] <= 1'b0;
          rsp   <= '{1'b1, sbba_pkg::ST_DONE, 3'd0, 8'd0};
          state <= S_RSP;
        end
        S_RSP: begin
          if (rsp_valid && rsp_ready) begin
            rsp_valid <= 1'b0;
            state     <= S_IDLE;
          end else begin
            rsp_valid <= 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Marks that the bit position for the set cycle comes from a scanned word.
  always_ff @(posedge clk) begin
    if (rst) begin
      lsb_valid <= 1'b0;
    end else begin
      lsb_valid <= (state == S_SCAN) && (rdata != sbba_pkg::ALL_ONES);
    end
  end

  assert property (@(posedge clk) disable iff (rst) rsp_valid |-> state == S_RSP)
    else $error("result valid outside response state");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_SET) |-> lsb_valid)
    else $error("bit set without a scan result");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_CLAIM) |-> !in_use[cur_slab])
    else $error("claiming a slab already in use");
  assert property (@(posedge clk) disable iff (rst)
    req_ready |-> !rsp_valid)
    else $error("request taken while a result is pending");

endmodule
`default_nettype wire

FILE: tb/slab_bitmap_block_allocator_tb.sv
// Self-checking testbench for the slab bitmap block allocator.
// Depends on sbba_pkg and the RTL; predicts each response from its own model of slabs and lists.
`timescale 1ns / 1ps
module slab_bitmap_block_allocator_tb;

  localparam int NSLAB = 8;
  localparam logic [3:0] LNULL = 4'd8;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  sbba_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  sbba_pkg::rsp_t rsp;

  slab_bitmap_block_allocator #(.NUM_SLABS(NSLAB)) i_dut (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predictor state: per-slab occupancy maps and the two slab lists.
  logic [255:0] slab_map [NSLAB];
  logic [NSLAB-1:0] claimed;
  logic [3:0] link_to [NSLAB];
  logic [3:0] partial_first;
  logic [3:0] full_first;

  sbba_pkg::req_t request_queue [$];
  sbba_pkg::rsp_t expected_rsp [$];
  int mismatch_count = 0;
  bit driver_done = 1'b0;
  bit hold_rsp = 1'b0;
  bit drain_wait = 1'b0;
  int requests_sent = 0;

  function automatic logic [3:0] next_of(input logic [3:0] s);
    return (link_to[s[2:0]] < NSLAB) ? link_to[s[2:0]] : LNULL;
  endfunction

  // Works out the response to one request and updates the predicted state.
  function automatic sbba_pkg::rsp_t predict_allocator(input sbba_pkg::req_t r);
    sbba_pkg::rsp_t o;
    int s;
    int b;
    int cur;
    bit found;
    o = '0;
    if (r.mode == sbba_pkg::MODE_ALLOC) begin
      if (partial_first >= NSLAB) begin
        s = 0;
        while (s < NSLAB && claimed[s]) s++;
        if (s == NSLAB) begin
          o.status = sbba_pkg::ST_EXHAUSTED;
          return o;
        end
        claimed[s] = 1'b1;
        slab_map[s] = 256'd1;
        link_to[s] = LNULL;
        partial_first = 4'(s);
      end
      s = partial_first;
      if (&slab_map[s]) begin
        o.status = sbba_pkg::ST_CORRUPT;
        return o;
      end
      b = 0;
      while (slab_map[s][b]) b++;
      slab_map[s][b] = 1'b1;
      if (&slab_map[s]) begin
        partial_first = next_of(4'(s));
        link_to[s] = full_first;
        full_first = 4'(s);
      end
      o.ok = 1'b1;
      o.status = sbba_pkg::ST_DONE;
      o.out_slab = 3'(s);
      o.out_block = 8'(b);
    end else begin
      s = r.slab_index;
      if (r.block_index == 0 || !claimed[s]) begin
        o.status = sbba_pkg::ST_IGNORED;
        return o;
      end
      if (&slab_map[s]) begin
        found = 1'b0;
        if (full_first == s) begin
          full_first = next_of(4'(s));
          found = 1'b1;
        end else begin
          cur = full_first;
          for (int k = 0; k < NSLAB && cur < NSLAB && !found; k++) begin
            if (next_of(4'(cur)) == s) begin
              link_to[cur] = next_of(4'(s));
              found = 1'b1;
            end else begin
              cur = next_of(4'(cur));
            end
          end
        end
        if (found) begin
          link_to[s] = partial_first;
          partial_first = 4'(s);
        end
      end
      slab_map[s][r.block_index] = 1'b0;
      o.ok = 1'b1;
    end
    return o;
  endfunction

  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
  endfunction

  function automatic sbba_pkg::req_t make_req(input logic m, input int s, input int b);
    sbba_pkg::req_t r;
    r.mode = m;
    r.slab_index = 3'(s);
    r.block_index = 8'(b);
    return r;
  endfunction

  // Driver: offers queued requests with random gaps and predicts on each transfer.
  int send_gap = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && req_ready) begin
        expected_rsp.push_back(predict_allocator(req));
        requests_sent <= requests_sent + 1;
      end
      if (!req_valid || req_ready) begin
        if (send_gap > 0 || drain_wait || request_queue.size() == 0) begin
          req_valid <= 1'b0;
          if (send_gap > 0) send_gap <= send_gap - 1;
        end else begin
          req <= request_queue.pop_front();
          req_valid <= 1'b1;
          send_gap <= gap_len();
        end
      end
    end
  end

  // Receiver readiness with random stalls, plus one long hold-off.
  int stall_left = 0;
  always @(posedge clk) begin
    if (hold_rsp) begin
      rsp_ready <= 1'b0;
    end else if (stall_left > 0) begin
      rsp_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      rsp_ready <= 1'b0;
      stall_left <= gap_len();
    end else begin
      rsp_ready <= 1'b1;
    end
  end

  // Monitor: compares each response transfer with the oldest prediction.
  sbba_pkg::rsp_t exp_r;
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      if (expected_rsp.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected response %p", rsp);
      end else begin
        exp_r = expected_rsp.pop_front();
        if (rsp.ok !== exp_r.ok || rsp.status !== exp_r.status ||
            rsp.out_slab !== exp_r.out_slab || rsp.out_block !== exp_r.out_block) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected %p actual %p", exp_r, rsp);
        end
      end
    end
  end

  // Random traffic: alloc-heavy or free-heavy bursts; frees pick random slabs and blocks, some at block 0 or 255.
  task automatic add_random(input int count);
    int free_pct;
    for (int i = 0; i < count; i++) begin
      if (i % 100 == 0) free_pct = $urandom_range(10, 90);
      if ($urandom_range(0, 99) >= free_pct)
        request_queue.push_back(make_req(sbba_pkg::MODE_ALLOC, $urandom_range(0, 7),
                                         $urandom_range(0, 255)));
      else if ($urandom_range(0, 9) < 8)
        request_queue.push_back(make_req(sbba_pkg::MODE_FREE, $urandom_range(0, 7),
                                         $urandom_range(1, 255)));
      else
        request_queue.push_back(make_req(sbba_pkg::MODE_FREE, $urandom_range(0, 7),
                                         $urandom_range(0, 1) ? 0 : 255));
    end
  endtask

  task automatic wait_drained();
    while (request_queue.size() != 0 || req_valid || expected_rsp.size() != 0)
      @(posedge clk);
  endtask

  int hold_cycles;
  initial begin
    for (int s = 0; s < NSLAB; s++) begin
      slab_map[s] = '0;
      link_to[s] = 4'd0;
    end
    claimed = '0;
    partial_first = LNULL;
    full_first = LNULL;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: frees that are ignored, first allocs, edge blocks.
    request_queue.push_back(make_req(sbba_pkg::MODE_FREE, 0, 5));
    request_queue.push_back(make_req(sbba_pkg::MODE_FREE, 7, 255));
    for (int i = 0; i < 4; i++)
      request_queue.push_back(make_req(sbba_pkg::MODE_ALLOC, 7, 255));
    request_queue.push_back(make_req(sbba_pkg::MODE_FREE, 0, 0));
    request_queue.push_back(make_req(sbba_pkg::MODE_FREE, 0, 2));
    request_queue.push_back(make_req(sbba_pkg::MODE_FREE, 0, 2));
    request_queue.push_back(make_req(sbba_pkg::MODE_FREE, 0, 255));
    request_queue.push_back(make_req(sbba_pkg::MODE_ALLOC, 0, 0));
    request_queue.push_back(make_req(sbba_pkg::MODE_FREE, 3, 9));
    wait_drained();

    // Fill the whole pool, hit exhaustion, and free back into full slabs.
    // Four blocks are already taken, so this leaves two exhausted requests.
    for (int i = 0; i < NSLAB * 255 - 2; i++)
      request_queue.push_back(make_req(sbba_pkg::MODE_ALLOC, 0, 0));
    request_queue.push_back(make_req(sbba_pkg::MODE_FREE, 3, 128));
    request_queue.push_back(make_req(sbba_pkg::MODE_FREE, 0, 64));
    request_queue.push_back(make_req(sbba_pkg::MODE_FREE, 7, 192));
    request_queue.push_back(make_req(sbba_pkg::MODE_FREE, 7, 63));
    for (int i = 0; i < 5; i++)
      request_queue.push_back(make_req(sbba_pkg::MODE_ALLOC, 0, 0));
    wait_drained();

    // Long receiver hold-off while the sender keeps offering requests.
    add_random(20);
    hold_rsp = 1'b1;
    hold_cycles = 0;
    while (hold_cycles < 200) begin
      @(posedge clk);
      hold_cycles++;
    end
    hold_rsp = 1'b0;

    add_random(30);
    // Pause the sender until every expected response has come back.
    while (req_valid) @(posedge clk);
    drain_wait = 1'b1;
    while (expected_rsp.size() != 0) @(posedge clk);
    drain_wait = 1'b0;
    add_random(30);

    wait_drained();
    repeat (50) @(posedge clk);
    if (mismatch_count == 0 && expected_rsp.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
